>>> hdl/rehn_pkg.sv
package rehn_pkg;

	localparam int CfgAddrW = 4;
	localparam logic [CfgAddrW-1:0] RegCameraX = 4'h0;
	localparam logic [CfgAddrW-1:0] RegCameraY = 4'h4;
	localparam logic [CfgAddrW-1:0] RegMaxDist = 4'h8;

	// front to back: one classified edge
	typedef struct packed {
		logic        valid_hit;
		logic [31:0] quot;
		logic        rem_zero;
		logic        last;
	} edge_res_t;

endpackage

>>> hdl/rehn_front.sv
module rehn_front
	import rehn_pkg::*;
#(
	parameter int DIR_FRAC_BITS = 15
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [31:0] camera_x,
	input  logic signed [31:0] camera_y,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_y,
	input  logic signed [31:0] start_x,
	input  logic signed [31:0] start_y,
	input  logic signed [31:0] end_x,
	input  logic signed [31:0] end_y,
	input  logic               last_edge,
	output logic               res_valid,
	input  logic               res_ready,
	output edge_res_t          res
);

	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StSub  = 3'd1;
	localparam logic [2:0] StMul  = 3'd2;
	localparam logic [2:0] StSum  = 3'd3;
	localparam logic [2:0] StDiv  = 3'd4;
	localparam logic [2:0] StOut  = 3'd5;

	logic [2:0] state_q;
	logic [4:0] bit_q;
	logic signed [15:0] drx_q, dry_q;
	logic signed [32:0] ex_q, ey_q, dx_q, dy_q;
	logic signed [49:0] p_dxey_q, p_dyex_q, p_dydx_q, p_dxdy_q;
	logic signed [65:0] p_eydx_q, p_exdy_q;
	logic signed [50:0] den_q, un_q;
	logic signed [66:0] tn_q;
	logic [49:0] dmag_q;
	logic [81:0] n_q, acc_q;
	logic [31:0] q_q;
	logic last_q, ok_q;
	logic [81:0] trial;

	assign in_ready  = (state_q == StIdle);
	assign res_valid = (state_q == StOut);
	assign trial = acc_q + ({32'd0, dmag_q} << bit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			bit_q   <= '0;
		end else begin
			case (state_q)
				StIdle: if (in_valid) state_q <= StSub;
				StSub:  state_q <= StMul;
				StMul:  state_q <= StSum;
				StSum: begin
					state_q <= StDiv;
					bit_q   <= 5'd31;
				end
				StDiv: begin
					if (!ok_q) state_q <= StOut;
					else begin
						bit_q <= bit_q - 5'd1;
						if (bit_q == 5'd0) state_q <= StOut;
					end
				end
				StOut: if (res_ready) state_q <= StIdle;
				default: state_q <= StIdle;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			StIdle: begin
				drx_q <= dir_x; dry_q <= dir_y; last_q <= last_edge;
				ex_q <= 33'(end_x) - 33'(start_x);
				ey_q <= 33'(end_y) - 33'(start_y);
				dx_q <= 33'(start_x) - 33'(camera_x);
				dy_q <= 33'(start_y) - 33'(camera_y);
			end
			StSub: begin
				p_dxey_q <= 50'(drx_q * ey_q);
				p_dyex_q <= 50'(dry_q * ex_q);
				p_dydx_q <= 50'(dry_q * dx_q);
				p_dxdy_q <= 50'(drx_q * dy_q);
				p_eydx_q <= 66'(ey_q * dx_q);
				p_exdy_q <= 66'(ex_q * dy_q);
			end
			StMul: begin
				den_q <= 51'(p_dxey_q) - 51'(p_dyex_q);
				un_q  <= 51'(p_dydx_q) - 51'(p_dxdy_q);
				tn_q  <= 67'(p_eydx_q) - 67'(p_exdy_q);
			end
			StSum: begin
				// fold sign of denominator into numerators
				logic signed [50:0] d, u;
				logic signed [66:0] t;
				d = den_q[50] ? -den_q : den_q;
				u = den_q[50] ? -un_q : un_q;
				t = den_q[50] ? -tn_q : tn_q;
				dmag_q <= d[49:0];
				n_q    <= ({15'd0, t} << DIR_FRAC_BITS) & {82{~t[66]}};
				acc_q  <= '0;
				q_q    <= '0;
				ok_q   <= (den_q != 0) && !u[50] && (u <= d) && !t[66]
					&& (({15'd0, t} << DIR_FRAC_BITS) < ({32'd0, d} << 32));
			end
			StDiv: begin
				if (ok_q && trial <= n_q) begin
					acc_q <= trial;
					q_q[bit_q] <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign res.valid_hit = ok_q;
	assign res.quot      = q_q;
	assign res.rem_zero  = (n_q == acc_q);
	assign res.last      = last_q;

endmodule

>>> hdl/rehn_queue.sv
module rehn_queue
	import rehn_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_valid,
	output logic      wr_ready,
	input  edge_res_t wr_data,
	output logic      rd_valid,
	input  logic      rd_ready,
	output edge_res_t rd_data
);

	edge_res_t mem_q [2];
	logic [1:0] cnt_q;
	logic wp_q, rp_q;
	logic push, pop;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign push = wr_valid && wr_ready;
	assign pop  = rd_valid && rd_ready;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; wp_q <= 1'b0; rp_q <= 1'b0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end

endmodule

>>> hdl/rehn_back.sv
module rehn_back
	import rehn_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [30:0] max_distance,
	input  logic        in_valid,
	output logic        in_ready,
	input  edge_res_t   in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        hit,
	output logic [30:0] nearest
);

	logic [30:0] best_q;
	logic any_q, ov_q, hit_q;
	logic [30:0] near_q;
	logic inr, take;

	assign in_ready = !ov_q || out_ready;
	assign take = in_valid && in_ready;
	assign inr = in_data.valid_hit &&
		((in_data.quot < {1'b0, max_distance}) ||
		 (in_data.quot == {1'b0, max_distance} && in_data.rem_zero));
	assign out_valid = ov_q;
	assign hit = hit_q;
	assign nearest = near_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0; any_q <= 1'b0;
		end else begin
			if (take && in_data.last) ov_q <= 1'b1;
			else if (out_valid && out_ready) ov_q <= 1'b0;
			if (take) begin
				if (in_data.last) any_q <= 1'b0;
				else if (inr) any_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			logic a;
			logic [30:0] b;
			a = any_q; b = best_q;
			if (inr && (!a || in_data.quot[30:0] < b)) b = in_data.quot[30:0];
			if (inr) a = 1'b1;
			best_q <= b;
			if (in_data.last) begin
				hit_q  <= a;
				near_q <= a ? b : max_distance;
			end
		end
	end

endmodule

>>> hdl/ray_edge_nearest_hit_unit.sv
// channel | dir    | payload
// s_axis  | in     | edge: dir, endpoints, tlast = last_edge
// m_axis  | out    | result: hit, nearest
// apb     | config | camera_x @0, camera_y @4, max_distance @8
// the front runs subtract, multiply and sum states, a 32-step restoring
// divider with one quotient bit per cycle, and a hand-off state; an edge
// rejected before division skips the divide steps; the divider sets the rate.
// the back folds one edge a cycle into the minimum unless m_axis stalls it.
// a two-entry queue parts front from back; m_axis stalls back up through it.
// reset clears control and loads the register defaults.
module ray_edge_nearest_hit_unit
	import rehn_pkg::*;
#(
	parameter int DIR_FRAC_BITS = 15
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// dir_x[15:0] dir_y[31:16] start_x[63:32] start_y[95:64] end_x[127:96] end_y[159:128]
	input  logic [159:0]        s_axis_tdata,
	input  logic                s_axis_tlast,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// nearest[30:0], zero [31]
	output logic [31:0]         m_axis_tdata,
	// hit
	output logic                m_axis_tuser,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [CfgAddrW-1:0] paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic signed [31:0] camx_q, camy_q;
	logic [30:0] maxd_q, nearest;
	logic fv, fr, bv, br;
	edge_res_t fres, bres;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			camx_q <= '0; camy_q <= '0; maxd_q <= 31'd65536000;
		end else if (psel && penable && pwrite) begin
			case (paddr)
				RegCameraX: camx_q <= pwdata;
				RegCameraY: camy_q <= pwdata;
				RegMaxDist: maxd_q <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr)
			RegCameraX: prdata = camx_q;
			RegCameraY: prdata = camy_q;
			RegMaxDist: prdata = {1'b0, maxd_q};
			default:    prdata = '0;
		endcase
	end

	rehn_front #(.DIR_FRAC_BITS(DIR_FRAC_BITS)) u_front (
		.clk, .arst_n, .camera_x(camx_q), .camera_y(camy_q),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.dir_x(s_axis_tdata[15:0]), .dir_y(s_axis_tdata[31:16]),
		.start_x(s_axis_tdata[63:32]), .start_y(s_axis_tdata[95:64]),
		.end_x(s_axis_tdata[127:96]), .end_y(s_axis_tdata[159:128]),
		.last_edge(s_axis_tlast), .res_valid(fv), .res_ready(fr), .res(fres)
	);

	rehn_queue u_queue (
		.clk, .arst_n, .wr_valid(fv), .wr_ready(fr), .wr_data(fres),
		.rd_valid(bv), .rd_ready(br), .rd_data(bres)
	);

	rehn_back u_back (
		.clk, .arst_n, .max_distance(maxd_q), .in_valid(bv), .in_ready(br),
		.in_data(bres), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.hit(m_axis_tuser), .nearest(nearest)
	);

	assign m_axis_tdata = {1'b0, nearest};

endmodule

>>> hdl/rehn_checker.sv
module rehn_checker
	import rehn_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tuser,
	input logic        pready
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable({m_axis_tuser, m_axis_tdata}))
		else $error("result dropped while stalled");
	a_top: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !m_axis_tdata[31])
		else $error("nearest overflow");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind ray_edge_nearest_hit_unit rehn_checker u_chk (
	.clk, .arst_n, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .pready
);

>>> verif/ray_hit_checker.sv
module ray_hit_checker
	import rehn_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	input  logic                s_axis_tready,
	input  logic [159:0]        s_axis_tdata,
	input  logic                s_axis_tlast,
	input  logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	input  logic [31:0]         m_axis_tdata,
	input  logic                m_axis_tuser,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [CfgAddrW-1:0] paddr,
	input  logic [31:0]         pwdata,
	input  logic                pready,
	output int                  errors,
	output int                  pending,
	output int                  edges_seen,
	output int                  rays_done,
	output int                  rays_hit
);

	localparam int DirFrac = 15;

	typedef struct {
		logic        hit;
		logic [30:0] nearest;
	} ray_result_t;

	ray_result_t ray_results_due[$];

	logic signed [31:0] cam_x, cam_y;
	logic [30:0]        range_limit;
	logic [30:0]        best_dist;
	logic               seen_hit;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	// exact ray-segment solve; true when hit within the range limit
	function automatic bit edge_distance(input logic signed [15:0] dxr, dyr,
			input logic signed [31:0] sx, sy, ex1, ey1, output logic [31:0] hit_len);
		longint ex, ey, dx, dy, den, un;
		logic signed [127:0] tn, n, d, q, rem, ex_w, ey_w, dx_w, dy_w;
		ex = longint'(ex1) - longint'(sx);
		ey = longint'(ey1) - longint'(sy);
		dx = longint'(sx) - longint'(cam_x);
		dy = longint'(sy) - longint'(cam_y);
		den = longint'(dxr) * ey - longint'(dyr) * ex;
		un = longint'(dyr) * dx - longint'(dxr) * dy;
		ex_w = ex;
		ey_w = ey;
		dx_w = dx;
		dy_w = dy;
		tn = ey_w * dx_w - ex_w * dy_w;
		hit_len = '0;
		if (den == 0)
			return 0;
		if (den < 0) begin
			den = -den;
			un = -un;
			tn = -tn;
		end
		if (un < 0 || un > den || tn < 0)
			return 0;
		n = tn <<< DirFrac;
		d = den;
		if (n >= (d <<< 32))
			return 0;
		q = n / d;
		rem = n - q * d;
		if (q < range_limit || (q == range_limit && rem == 0)) begin
			hit_len = q[31:0];
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [31:0] hit_len;
		ray_result_t want;
		if (!arst_n) begin
			cam_x = '0;
			cam_y = '0;
			range_limit = 31'd65536000;
			best_dist = 31'd65536000;
			seen_hit = 1'b0;
			ray_results_due.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr)
				RegCameraX: cam_x = pwdata;
				RegCameraY: cam_y = pwdata;
				RegMaxDist: range_limit = pwdata[30:0];
				default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (ray_results_due.size() == 0) begin
					report_mismatch("unexpected result", m_axis_tdata, '0);
				end else begin
					want = ray_results_due.pop_front();
					rays_done++;
					if (m_axis_tuser)
						rays_hit++;
					if (m_axis_tuser !== want.hit)
						report_mismatch("hit", m_axis_tuser, want.hit);
					if (m_axis_tdata[30:0] !== want.nearest)
						report_mismatch("nearest", m_axis_tdata[30:0], want.nearest);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				edges_seen++;
				if (edge_distance(s_axis_tdata[15:0], s_axis_tdata[31:16],
						s_axis_tdata[63:32], s_axis_tdata[95:64],
						s_axis_tdata[127:96], s_axis_tdata[159:128], hit_len)) begin
					if (!seen_hit || hit_len[30:0] < best_dist)
						best_dist = hit_len[30:0];
					seen_hit = 1'b1;
				end
				if (s_axis_tlast) begin
					want.hit = seen_hit;
					want.nearest = seen_hit ? best_dist : range_limit;
					ray_results_due = {ray_results_due, want};
					best_dist = range_limit;
					seen_hit = 1'b0;
				end
			end
		end
		pending = ray_results_due.size();
	end

	initial begin
		errors = 0;
		pending = 0;
		edges_seen = 0;
		rays_done = 0;
		rays_hit = 0;
	end

	final begin
		if (ray_results_due.size() != 0)
			$display("%0d results never arrived", ray_results_due.size());
	end

endmodule

>>> verif/testbench.sv
module testbench;
	import rehn_pkg::*;

	localparam int CycleLimit = 1000000;
	localparam int DrainCycles = 120;

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	// dir_x, dir_y, start_x, start_y, end_x, end_y from bit 0 up
	logic [159:0]        s_axis_tdata;
	logic                s_axis_tlast;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	// nearest, zero pad
	logic [31:0]         m_axis_tdata;
	// hit
	logic                m_axis_tuser;
	logic                psel, penable, pwrite, pready;
	logic [CfgAddrW-1:0] paddr;
	logic [31:0]         pwdata, prdata;

	int errors, pending, edges_seen, rays_done, rays_hit;
	int idle_pct, stall_pct, cycles;
	bit long_hold, hold_go;
	logic signed [31:0] cam_x, cam_y;

	ray_edge_nearest_hit_unit dut (.*);

	ray_hit_checker hit_chk (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("testbench failed");
			$finish;
		end
	end

	always @(negedge clk)
		m_axis_tready <= long_hold ? 1'b0 : ($urandom_range(99) >= stall_pct);

	// long receiver hold-off so the queue fills and the input stalls
	initial begin
		long_hold = 1'b0;
		wait (hold_go);
		long_hold = 1'b1;
		repeat (400) @(posedge clk);
		long_hold = 1'b0;
	end

	task automatic reg_write(input logic [CfgAddrW-1:0] addr, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// call at a falling edge; returns at a falling edge after the transfer
	task automatic send_edge(input logic [15:0] dx, dy, input logic [31:0] sx, sy,
			ex, ey, input logic last);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {ey, ex, sy, sx, dy, dx};
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (DrainCycles) @(negedge clk);
	endtask

	// an edge that crosses the ray at a chosen distance, or pure noise
	task automatic random_edge();
		logic signed [15:0] dx, dy;
		longint d, px, py, vx, vy, k;
		case ($urandom_range(4))
		0: begin dx = 16'sd32767; dy = 16'sd0; end
		1: begin dx = 16'sd0; dy = -16'sd32768; end
		2: begin dx = 16'sd23170; dy = 16'sd23170; end
		default: begin dx = 16'($urandom); dy = 16'($urandom); end
		endcase
		if ($urandom_range(9) < 2) begin
			send_edge(dx, dy, $urandom, $urandom, $urandom, $urandom,
				$urandom_range(3) == 0);
		end else begin
			d = longint'($urandom_range(1200)) <<< 16;
			px = longint'(cam_x) + ((d * dx) >>> 15);
			py = longint'(cam_y) + ((d * dy) >>> 15);
			vx = longint'($urandom_range(100 << 16)) - (50 << 16);
			vy = longint'($urandom_range(100 << 16)) - (50 << 16);
			k = $urandom_range(3) + 1;
			send_edge(dx, dy, 32'(px - vx), 32'(py - vy), 32'(px + k * vx),
				32'(py + k * vy), $urandom_range(3) == 0);
		end
	endtask

	task automatic set_camera(input logic [31:0] x, y, input logic [31:0] limit);
		cam_x = x;
		cam_y = y;
		reg_write(RegCameraX, x);
		reg_write(RegCameraY, y);
		reg_write(RegMaxDist, limit);
	endtask

	initial begin
		cycles = 0;
		hold_go = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cam_x = '0;
		cam_y = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed edges at reset settings, camera at origin
		send_edge(16'sd32767, 0, 32'sd10 << 16, -32'sd5 << 16, 32'sd10 << 16,
			32'sd5 << 16, 1'b0);
		send_edge(16'sd32767, 0, 32'sd4 << 16, 0, 32'sd4 << 16, 32'sd8 << 16, 1'b0);
		send_edge(16'sd32767, 0, 32'sd4 << 16, -32'sd8 << 16, 32'sd4 << 16, 0, 1'b1);
		send_edge(0, 0, 32'sd3 << 16, -32'sd1 << 16, 32'sd3 << 16, 32'sd1 << 16, 1'b1);
		send_edge(16'sd32767, 0, 32'sd7 << 16, 32'sd1 << 16, 32'sd7 << 16,
			32'sd1 << 16, 1'b1);
		send_edge(16'sd32767, 0, 32'sd3 << 16, 0, 32'sd9 << 16, 0, 1'b1);
		send_edge(16'sd32767, 0, 0, -32'sd1 << 16, 0, 32'sd1 << 16, 1'b1);
		send_edge(-16'sd32768, 0, 32'sd6 << 16, -32'sd1 << 16, 32'sd6 << 16,
			32'sd1 << 16, 1'b1);
		send_edge(16'sd1, 16'sd0, 32'sd2000 << 16, -32'sd1 << 16, 32'sd2000 << 16,
			32'sd1 << 16, 1'b1);
		send_edge(16'sd16384, 0, 32'sd20 << 16, -32'sd1 << 16, 32'sd20 << 16,
			32'sd1 << 16, 1'b0);
		send_edge(16'sd16384, 0, 32'sd20 << 16, -32'sd1 << 16, 32'sd20 << 16,
			32'sd1 << 16, 1'b1);
		send_edge(16'h8000, 16'h7fff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h8000_0000, 1'b1);
		send_edge(16'h7fff, 16'h8000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
			32'h7fff_ffff, 1'b1);
		send_edge(16'hffff, 16'hffff, 32'hffff_ffff, 32'h0, 32'h0, 32'hffff_ffff, 1'b1);
		wait_idle();

		// limit at 1000 with edges at 1000 and 1001, then limit zero, then largest
		set_camera(0, 0, 32'd65536000);
		send_edge(16'sd32767, 0, 32'sd1000 << 16, -32'sd1 << 16, 32'sd1000 << 16,
			32'sd1 << 16, 1'b1);
		send_edge(16'sd32767, 0, 32'sd1001 << 16, -32'sd1 << 16, 32'sd1001 << 16,
			32'sd1 << 16, 1'b1);
		wait_idle();

		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
			0: set_camera(0, 0, 0);
			1: set_camera(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
			2: set_camera(32'h8000_0000, 32'h7fff_ffff, 32'd65536000);
			default: set_camera(32'($urandom_range(2000 << 16)) - (1000 << 16),
				32'($urandom_range(2000 << 16)) - (1000 << 16),
				$urandom_range(1500 << 16));
			endcase
			case (phase % 4)
			0: begin idle_pct = 0; stall_pct = 0; end
			1: begin idle_pct = 62; stall_pct = 0; end
			2: begin idle_pct = 0; stall_pct = 62; end
			default: begin idle_pct = 32; stall_pct = 32; end
			endcase
			if (phase == 3)
				hold_go = 1'b1;
			for (int i = 0; i < 135; i++) begin
				random_edge();
				if (phase == 5 && i == 60) begin
					s_axis_tvalid <= 1'b0;
					wait (pending == 0);
					@(negedge clk);
				end
			end
			// close the open ray so the next setting starts clean
			send_edge(0, 0, 0, 0, 0, 0, 1'b1);
			wait_idle();
		end

		idle_pct = 0;
		stall_pct = 0;
		$display("%0d edges sent over %0d rays, %0d rays hit", edges_seen, rays_done,
			rays_hit);
		$display("settings covered: reset, zero and full limit, extreme cameras, random");
		if (errors == 0 && pending == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule
